### src/cep_pkg.sv
// ----------------------------------------------------------------------------
// cep_pkg: shared constants for the Chebyshev series evaluator
// Holds the field widths, operation and register codes and the fixed-point
// constants shared by the evaluator, its multiplier and its coefficient store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cep_pkg;

    localparam int MAX_ORDER_DEF = 15;

    localparam int ORDER_W    = 4;
    localparam int COEF_W     = 32;
    localparam int T_W        = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int TERM_W     = 34;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORDER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORDER = CFG_IDX_W'(1);

    localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(10);

    localparam logic signed [T_W-1:0] T_ONE  = 32'sh4000_0000;
    localparam logic signed [T_W-1:0] T_SMAX = 32'sh7fff_ffff;
    localparam logic signed [T_W-1:0] T_SMIN = 32'sh8000_0000;

    localparam logic signed [PROD_W-1:0] RND28  = PROD_W'(64'sd268435456);
    localparam logic signed [PROD_W-1:0] RND29  = PROD_W'(64'sd536870912);
    localparam logic signed [PROD_W-1:0] T_MAXP = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] T_MINP = PROD_W'(-64'sd2147483648);

endpackage

### src/cep_mul.sv
// ----------------------------------------------------------------------------
// cep_mul: shared signed multiplier
// One signed multiply per cycle with a registered product; every product of
// the evaluator passes through this unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cep_mul (
    input  logic                                i_clk,
    input  logic signed [cep_pkg::MUL_W-1:0]    i_a,
    input  logic signed [cep_pkg::MUL_W-1:0]    i_b,
    output logic signed [cep_pkg::PROD_W-1:0]   o_p
);

    logic signed [cep_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### src/cep_coef_mem.sv
// ----------------------------------------------------------------------------
// cep_coef_mem: coefficient store
// Single write port and single read port with registered read data, addressed
// by x order and y order side by side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cep_coef_mem #(
    parameter int AW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [cep_pkg::COEF_W-1:0]    i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [cep_pkg::COEF_W-1:0]    o_rdata
);

    logic [cep_pkg::COEF_W-1:0] r_mem [2**AW];
    logic [cep_pkg::COEF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/chebyshev_2d_series_eval_unit.sv
// ----------------------------------------------------------------------------
// chebyshev_2d_series_eval_unit: two-dimensional Chebyshev series evaluator
// Coefficient write: no result, busy stays low.
// Evaluation: every product goes through the single shared multiplier, and the
// row pass reads one coefficient per cycle (orders clamped to MAX_ORDER).
// One evaluation at a time; busy is high until the result strobe.
// Synchronous active-low reset clears control and sets both orders to 10.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chebyshev_2d_series_eval_unit #(
    parameter int MAX_ORDER = cep_pkg::MAX_ORDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_op,
    input  logic [cep_pkg::ORDER_W-1:0]           i_coef_x_index,
    input  logic [cep_pkg::ORDER_W-1:0]           i_coef_y_index,
    input  logic signed [cep_pkg::COEF_W-1:0]     i_coef_value,
    input  logic signed [cep_pkg::T_W-1:0]        i_point_x,
    input  logic signed [cep_pkg::T_W-1:0]        i_point_y,
    output logic                                  o_result_valid,
    output logic signed [cep_pkg::OUT_W-1:0]      o_series_value,
    output logic                                  o_overflow,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cep_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cep_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int IW    = $clog2(MAX_ORDER + 1);
    localparam int AW    = 2 * IW;
    localparam int AMW   = cep_pkg::TERM_W + IW;
    localparam int XW    = AMW + 33;
    localparam int ZRAW  = AMW + 3 + IW + 1;
    localparam int ZACW  = (ZRAW > cep_pkg::OUT_W + 1) ? ZRAW : cep_pkg::OUT_W + 1;
    localparam int MW    = cep_pkg::MUL_W;
    localparam int PW    = cep_pkg::PROD_W;
    localparam int TW    = cep_pkg::T_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TMUL,
        S_TACC,
        S_INNER,
        S_XHI,
        S_XLO,
        S_XSUM,
        S_XADD,
        S_DONE
    } t_state;

    t_state r_state;

    logic [cep_pkg::ORDER_W-1:0] r_x_order;
    logic [cep_pkg::ORDER_W-1:0] r_y_order;

    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic                    r_result_valid;
    logic signed [cep_pkg::OUT_W-1:0] r_series_value;
    logic                    r_overflow;

    logic signed [TW-1:0]    r_tx [MAX_ORDER+1];
    logic signed [TW-1:0]    r_ty [MAX_ORDER+1];
    logic signed [TW-1:0]    r_py;
    logic signed [TW-1:0]    r_tp;
    logic signed [TW-1:0]    r_tm1;
    logic signed [TW-1:0]    r_tm2;
    logic                    r_dim;
    logic [IW:0]             r_k;
    logic [IW-1:0]           r_m;
    logic [IW:0]             r_n;
    logic [IW-1:0]           r_n1;
    logic signed [cep_pkg::TERM_W-1:0] r_term;
    logic signed [AMW-1:0]   r_am;
    logic signed [XW-1:0]    r_accx;
    logic signed [ZACW-1:0]  r_z;
    logic                    r_ovf;

    logic [IW-1:0]           mx;
    logic [IW-1:0]           ny;
    logic [IW-1:0]           lim;
    logic                    acc;
    logic                    acc_eval;
    logic                    x_gen;
    logic                    y_gen;
    logic                    issue;
    logic                    drained;
    logic                    k_last;

    logic signed [MW-1:0]    mul_a;
    logic signed [MW-1:0]    mul_b;
    logic signed [PW-1:0]    prod;

    logic signed [PW-1:0]    rec_q;
    logic signed [PW-1:0]    rec_v;
    logic                    rec_hi;
    logic                    rec_lo;
    logic signed [TW-1:0]    t_new;
    logic signed [PW-1:0]    term_full;
    logic signed [AMW-17:0]  am_hi;

    logic                    z_sat_hi;
    logic                    z_sat_lo;
    logic signed [cep_pkg::OUT_W-1:0] z_out;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [AW-1:0]           mem_raddr;
    logic [cep_pkg::COEF_W-1:0] mem_rdata;

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = !busy && !start;
    assign o_result_valid = r_result_valid;
    assign o_series_value = r_series_value;
    assign o_overflow     = r_overflow;

    always_comb begin
        if (int'(r_x_order) > MAX_ORDER) begin
            mx = IW'(MAX_ORDER);
        end else begin
            mx = IW'(r_x_order);
        end
        if (int'(r_y_order) > MAX_ORDER) begin
            ny = IW'(MAX_ORDER);
        end else begin
            ny = IW'(r_y_order);
        end
    end

    assign lim      = r_dim ? ny : mx;
    assign acc      = start && !busy;
    assign acc_eval = acc && (i_op == cep_pkg::OP_EVAL);
    assign x_gen    = ({1'b0, mx} >= (IW + 1)'(2));
    assign y_gen    = ({1'b0, ny} >= (IW + 1)'(2));
    assign issue    = (r_state == S_INNER) && (r_n <= {1'b0, ny});
    assign drained  = !issue && !r_v1 && !r_v2 && !r_v3;
    assign k_last   = (r_k == {1'b0, lim});

    assign mem_we = acc && (i_op == cep_pkg::OP_WRITE)
                    && (int'(i_coef_x_index) <= MAX_ORDER)
                    && (int'(i_coef_y_index) <= MAX_ORDER);
    assign mem_waddr = {IW'(i_coef_x_index), IW'(i_coef_y_index)};
    assign mem_raddr = {r_m, r_n[IW-1:0]};

    cep_coef_mem #(
        .AW (AW)
    ) u_coef_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign am_hi = $signed(r_am[AMW-1:16]);

    always_comb begin
        unique case (r_state)
            S_TMUL: begin
                mul_a = MW'(r_tm1);
                mul_b = MW'(r_tp);
            end
            S_INNER: begin
                mul_a = MW'($signed(mem_rdata));
                mul_b = MW'(r_ty[r_n1]);
            end
            S_XHI: begin
                mul_a = MW'(am_hi);
                mul_b = MW'(r_tx[r_m]);
            end
            S_XLO: begin
                mul_a = $signed({{(MW - 16){1'b0}}, r_am[15:0]});
                mul_b = MW'(r_tx[r_m]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cep_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    always_comb begin
        rec_q  = (prod + cep_pkg::RND28) >>> 29;
        rec_v  = rec_q - PW'(r_tm2);
        rec_hi = (rec_v > cep_pkg::T_MAXP);
        rec_lo = (rec_v < cep_pkg::T_MINP);
        if (rec_hi) begin
            t_new = cep_pkg::T_SMAX;
        end else if (rec_lo) begin
            t_new = cep_pkg::T_SMIN;
        end else begin
            t_new = TW'(rec_v);
        end
        term_full = (prod + cep_pkg::RND29) >>> 30;
    end

    assign z_sat_hi = !r_z[ZACW-1] && (|r_z[ZACW-2:cep_pkg::OUT_W-1]);
    assign z_sat_lo = r_z[ZACW-1] && !(&r_z[ZACW-2:cep_pkg::OUT_W-1]);

    always_comb begin
        priority if (z_sat_hi) begin
            z_out = {1'b0, {(cep_pkg::OUT_W - 1){1'b1}}};
        end else if (z_sat_lo) begin
            z_out = {1'b1, {(cep_pkg::OUT_W - 1){1'b0}}};
        end else begin
            z_out = cep_pkg::OUT_W'(r_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_x_order      <= cep_pkg::ORDER_RST;
            r_y_order      <= cep_pkg::ORDER_RST;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_result_valid <= 1'b0;
            r_series_value <= '0;
            r_overflow     <= 1'b0;
        end else begin
            r_v1           <= issue;
            r_v2           <= r_v1;
            r_v3           <= r_v2;
            r_result_valid <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    cep_pkg::REG_X_ORDER: r_x_order <= i_cfg_data[cep_pkg::ORDER_W-1:0];
                    cep_pkg::REG_Y_ORDER: r_y_order <= i_cfg_data[cep_pkg::ORDER_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc_eval) begin
                        if (x_gen || y_gen) begin
                            r_state <= S_TMUL;
                        end else begin
                            r_state <= S_INNER;
                        end
                    end
                end
                S_TMUL: r_state <= S_TACC;
                S_TACC: begin
                    if (!k_last || (!r_dim && y_gen)) begin
                        r_state <= S_TMUL;
                    end else begin
                        r_state <= S_INNER;
                    end
                end
                S_INNER: begin
                    if (drained) begin
                        r_state <= S_XHI;
                    end
                end
                S_XHI:  r_state <= S_XLO;
                S_XLO:  r_state <= S_XSUM;
                S_XSUM: r_state <= S_XADD;
                S_XADD: begin
                    if (r_m == mx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_INNER;
                    end
                end
                S_DONE: begin
                    r_state        <= S_IDLE;
                    r_series_value <= z_out;
                    r_overflow     <= r_ovf || z_sat_hi || z_sat_lo;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_n  <= r_n + (IW + 1)'(1);
            r_n1 <= r_n[IW-1:0];
        end
        if (r_v2) begin
            r_term <= cep_pkg::TERM_W'(term_full);
        end
        if (r_v3) begin
            r_am <= r_am + AMW'(r_term);
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc_eval) begin
                    r_tx[0] <= cep_pkg::T_ONE;
                    r_tx[1] <= i_point_x;
                    r_ty[0] <= cep_pkg::T_ONE;
                    r_ty[1] <= i_point_y;
                    r_py    <= i_point_y;
                    r_dim   <= !x_gen;
                    r_tm1   <= x_gen ? i_point_x : i_point_y;
                    r_tp    <= x_gen ? i_point_x : i_point_y;
                    r_tm2   <= cep_pkg::T_ONE;
                    r_k     <= (IW + 1)'(2);
                    r_m     <= '0;
                    r_n     <= '0;
                    r_am    <= '0;
                    r_z     <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            S_TACC: begin
                if (r_dim) begin
                    r_ty[r_k[IW-1:0]] <= t_new;
                end else begin
                    r_tx[r_k[IW-1:0]] <= t_new;
                end
                if (rec_hi || rec_lo) begin
                    r_ovf <= 1'b1;
                end
                if (!k_last) begin
                    r_k   <= r_k + (IW + 1)'(1);
                    r_tm2 <= r_tm1;
                    r_tm1 <= t_new;
                end else if (!r_dim && y_gen) begin
                    r_dim <= 1'b1;
                    r_k   <= (IW + 1)'(2);
                    r_tm1 <= r_py;
                    r_tp  <= r_py;
                    r_tm2 <= cep_pkg::T_ONE;
                end
            end
            S_XLO: begin
                r_accx <= XW'(prod) <<< 16;
            end
            S_XSUM: begin
                r_accx <= r_accx + XW'(prod) + XW'(cep_pkg::RND29);
            end
            S_XADD: begin
                r_z  <= r_z + ZACW'(r_accx >>> 30);
                r_m  <= r_m + IW'(1);
                r_n  <= '0;
                r_am <= '0;
            end
            default: ;
        endcase
    end

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished evaluation");

    a_pipe_only_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> (r_state == S_INNER))
        else $error("row pipeline active outside the row pass");

    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == cep_pkg::OP_EVAL) |=> busy)
        else $error("evaluation transfer did not raise busy");

    a_row_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XHI) |-> ((r_n > {1'b0, ny}) && !r_v3))
        else $error("row sum taken before all coefficients were read");

endmodule
